>>> sv/tof_pixel_depth_gate_colormap_unit_defines.svh
// Assertion helpers for the depth/colormap block.
`ifndef TOF_PIXEL_DEPTH_GATE_COLORMAP_UNIT_DEFINES_SVH
`define TOF_PIXEL_DEPTH_GATE_COLORMAP_UNIT_DEFINES_SVH

// Check cons on every clock edge at which ante holds; quiet during reset.
`define TPDC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cond on every clock edge; quiet during reset.
`define TPDC_ASSERT_ALWAYS(lbl, cond, msg) \
  `TPDC_ASSERT_IMPLIES(lbl, 1'b1, cond, msg)

`endif

>>> sv/tpdc_pkg.sv
package tpdc_pkg;

  // Sensor and field widths
  localparam int PHASE_FULL_SCALE = 30000;
  localparam int SAMPLE_BITS      = 16;
  localparam int SAMPLE_W         = 16;
  localparam int DIST_W           = 15;
  localparam int COL_W            = 8;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_IDX_W        = 3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  // range_mm * phase and the reciprocal division by the full scale
  localparam int PROD_W      = DIST_W + SAMPLE_W;
  localparam int FS_W        = 16;
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W     = 32;
  localparam int EST_W       = PROD_W + RECIP_W;
  localparam int BACK_W      = PROD_W + FS_W;
  localparam logic [FS_W-1:0] FS_CONST = FS_W'(PHASE_FULL_SCALE);
  localparam logic [RECIP_W-1:0] PHASE_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / PHASE_FULL_SCALE);

  // Color ramp
  localparam int RAMP_Q_W = 11;
  localparam int RAMP_N_W = DIST_W + RAMP_Q_W;
  localparam logic [RAMP_Q_W-1:0] RAMP_SPAN = 11'd1275;
  localparam logic [RAMP_Q_W-1:0] SEG_1     = 11'd255;
  localparam logic [RAMP_Q_W-1:0] SEG_2     = 11'd510;
  localparam logic [RAMP_Q_W-1:0] SEG_3     = 11'd765;
  localparam logic [RAMP_Q_W-1:0] SEG_4     = 11'd1020;
  localparam logic [COL_W-1:0]    COL_FULL  = 8'd255;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMP_MIN   = 3'd0,
    CFG_AMP_MAX   = 3'd1,
    CFG_RANGE_MM  = 3'd2,
    CFG_DIST_MIN  = 3'd3,
    CFG_DIST_MAX  = 3'd4,
    CFG_COLOR_MIN = 3'd5,
    CFG_COLOR_MAX = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_BLACK,
    CLS_RED,
    CLS_MAGENTA,
    CLS_RAMP
  } color_cls_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] amplitude_min;
    logic [SAMPLE_W-1:0] amplitude_max;
    logic [DIST_W-1:0]   range_mm;
    logic [DIST_W-1:0]   distance_min;
    logic [DIST_W-1:0]   distance_max;
    logic [DIST_W-1:0]   color_min;
    logic [DIST_W-1:0]   color_max;
  } cfg_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic              gate;
    logic [PROD_W-1:0] prod;
  } pix_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QPTR_W:0]   count;
  } q_stat_t;

  // Gated distance and color class handed to the ramp stage
  typedef struct packed {
    logic [DIST_W-1:0] dist_mm;
    color_cls_t        cls;
    logic [DIST_W-1:0] offset;
    logic [DIST_W-1:0] span;
  } ramp_t;

endpackage

>>> sv/tof_pixel_depth_gate_colormap_unit.sv
// Time-of-flight pixel to depth and false color. Each transaction on the in_
// channel carries one raw pixel (phase, amplitude); each transaction on the out_
// channel returns its distance in millimeters (zero marks an invalid pixel) and
// an RGB color from a five-segment rainbow ramp between color_min and color_max,
// black for invalid pixels, red below the ramp or for an empty span, magenta
// above it. Results leave in input order, one per pixel. The block takes one
// pixel per clock and delivers one result per clock as long as out_ready stays
// high; an accepted pixel passes four distance stages (reciprocal multiply,
// back-multiply, correction, classify), one stage that scales the ramp offset by
// 1275, the eleven-stage restoring divider that places the pixel on the ramp,
// and the output register. A four-entry queue sits between the classifying
// front and the arithmetic back; when a waiting result stalls the back end, the
// queue keeps taking pixels until it holds four, then in_ready drops. Registers
// are written through the cfg_ channel, which is always ready; write them only
// while no pixel is in flight.
module tof_pixel_depth_gate_colormap_unit
  import tpdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_phase,
  input  logic [SAMPLE_W-1:0]   in_amplitude,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIST_W-1:0]     out_distance_mm,
  output logic [COL_W-1:0]      out_red,
  output logic [COL_W-1:0]      out_green,
  output logic [COL_W-1:0]      out_blue,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "tof_pixel_depth_gate_colormap_unit_defines.svh"

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  logic    push;
  pix_t    push_data;
  logic    pop;
  pix_t    pop_data;
  logic    back_en;
  logic    ramp_valid;
  ramp_t   ramp_data;

  // Register file: ignore writes to unused indexes, keep each register's width
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_AMP_MIN:   cfg_nxt.amplitude_min = cfg_wdata;
        CFG_AMP_MAX:   cfg_nxt.amplitude_max = cfg_wdata;
        CFG_RANGE_MM:  cfg_nxt.range_mm      = cfg_wdata[DIST_W-1:0];
        CFG_DIST_MIN:  cfg_nxt.distance_min  = cfg_wdata[DIST_W-1:0];
        CFG_DIST_MAX:  cfg_nxt.distance_max  = cfg_wdata[DIST_W-1:0];
        CFG_COLOR_MIN: cfg_nxt.color_min     = cfg_wdata[DIST_W-1:0];
        CFG_COLOR_MAX: cfg_nxt.color_max     = cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amplitude_min <= 16'd50;
      cfg_r.amplitude_max <= 16'd60000;
      cfg_r.range_mm      <= 15'd12500;
      cfg_r.distance_min  <= 15'd300;
      cfg_r.distance_max  <= 15'd12500;
      cfg_r.color_min     <= 15'd0;
      cfg_r.color_max     <= 15'd15000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: gate the pixel on amplitude and phase, form range_mm * phase
  tpdc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_phase     (in_phase),
    .in_amplitude (in_amplitude),
    .cfg          (cfg_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  // Hold classified pixels while the back end stalls
  tpdc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Back, first half: divide by the full scale, gate on the distance window,
  // pick the color class
  tpdc_depth u_depth (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (back_en),
    .avail     (!q_stat.empty),
    .pix       (pop_data),
    .cfg       (cfg_r),
    .pop       (pop),
    .out_valid (ramp_valid),
    .out_data  (ramp_data)
  );

  // Back, second half: place the distance on the ramp, drive the output register;
  // the whole back end advances whenever that register is free or being drained
  tpdc_ramp u_ramp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (ramp_valid),
    .in_data         (ramp_data),
    .en              (back_en),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_distance_mm (out_distance_mm),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue)
  );

  // An invalid pixel must come out black
  `TPDC_ASSERT_IMPLIES(a_invalid_is_black, out_valid && out_distance_mm == '0, out_red == '0 && out_green == '0 && out_blue == '0, "invalid pixel not black")
  // A valid distance must lie inside the distance window
  `TPDC_ASSERT_IMPLIES(a_dist_in_window, out_valid && out_distance_mm != '0, out_distance_mm >= cfg_r.distance_min && out_distance_mm <= cfg_r.distance_max, "distance outside window")
  // The queue never holds more than its depth
  `TPDC_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= (QPTR_W+1)'(QDEPTH), "queue overflow")

endmodule

>>> sv/tpdc_queue.sv
module tpdc_queue
  import tpdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  pix_t    push_data,
  input  logic    pop,
  output pix_t    pop_data,
  output q_stat_t q_stat
);

  pix_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

>>> sv/tpdc_front.sv
module tpdc_front
  import tpdc_pkg::*;
(
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_phase,
  input  logic [SAMPLE_W-1:0] in_amplitude,
  input  cfg_t                cfg,
  input  q_stat_t             q_stat,
  output logic                push,
  output pix_t                push_data
);

  logic [SAMPLE_W-1:0] phase_m;
  logic [SAMPLE_W-1:0] amp_m;

  always_comb begin
    phase_m = in_phase & SAMPLE_MASK;
    amp_m   = in_amplitude & SAMPLE_MASK;
    // Mark pixels that are too weak, saturated, or carry no phase as invalid
    push_data.gate = (amp_m >= cfg.amplitude_min) && (amp_m <= cfg.amplitude_max) &&
                     (phase_m != '0);
    push_data.prod = PROD_W'(cfg.range_mm) * PROD_W'(phase_m);
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

endmodule

>>> sv/tpdc_depth.sv
module tpdc_depth
  import tpdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  avail,
  input  pix_t  pix,
  input  cfg_t  cfg,
  output logic  pop,
  output logic  out_valid,
  output ramp_t out_data
);

  // Stage 1: product times reciprocal of the full scale
  logic              v1_r;
  logic              gate1_r;
  logic [PROD_W-1:0] prod1_r;
  logic [EST_W-1:0]  est1_r;
  // Stage 2: estimated quotient and its back-product
  logic              v2_r;
  logic              gate2_r;
  logic [PROD_W-1:0] prod2_r;
  logic [PROD_W-1:0] quo2_r;
  logic [PROD_W-1:0] back2_r;
  logic [PROD_W-1:0] quo2_nxt;
  logic [BACK_W-1:0] back2_full;
  // Stage 3: corrected and gated distance
  logic              v3_r;
  logic [DIST_W-1:0] dist3_r, dist3_nxt;
  logic [PROD_W-1:0] rem3;
  logic [PROD_W-1:0] dist3_full;
  // Stage 4: color class
  logic              v4_r;
  ramp_t             ramp4_r, ramp4_nxt;

  assign pop = en && avail;

  always_comb begin
    quo2_nxt   = est1_r[RECIP_SHIFT +: PROD_W];
    back2_full = BACK_W'(quo2_nxt) * BACK_W'(FS_CONST);

    // The estimate is low by at most one: fix it with one compare
    rem3       = prod2_r - back2_r;
    dist3_full = quo2_r + PROD_W'(rem3 >= PROD_W'(FS_CONST));
    if (gate2_r && (dist3_full >= PROD_W'(cfg.distance_min)) &&
        (dist3_full <= PROD_W'(cfg.distance_max))) begin
      dist3_nxt = dist3_full[DIST_W-1:0];
    end else begin
      dist3_nxt = '0;
    end

    ramp4_nxt.dist_mm = dist3_r;
    ramp4_nxt.offset  = dist3_r - cfg.color_min;
    ramp4_nxt.span    = cfg.color_max - cfg.color_min;
    if (dist3_r == '0) begin
      ramp4_nxt.cls = CLS_BLACK;
    end else if (dist3_r < cfg.color_min) begin
      ramp4_nxt.cls = CLS_RED;
    end else if (dist3_r > cfg.color_max) begin
      ramp4_nxt.cls = CLS_MAGENTA;
    end else if (cfg.color_max == cfg.color_min) begin
      ramp4_nxt.cls = CLS_RED;
    end else begin
      ramp4_nxt.cls = CLS_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= avail;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gate1_r <= pix.gate;
      prod1_r <= pix.prod;
      est1_r  <= EST_W'(pix.prod) * EST_W'(PHASE_RECIP);
      gate2_r <= gate1_r;
      prod2_r <= prod1_r;
      quo2_r  <= quo2_nxt;
      back2_r <= back2_full[PROD_W-1:0];
      dist3_r <= dist3_nxt;
      ramp4_r <= ramp4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = ramp4_r;

endmodule

>>> sv/tpdc_ramp.sv
module tpdc_ramp
  import tpdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ramp_t             in_data,
  output logic              en,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_distance_mm,
  output logic [COL_W-1:0]  out_red,
  output logic [COL_W-1:0]  out_green,
  output logic [COL_W-1:0]  out_blue
);

  // Stage 0 holds offset*1275; stage k resolves quotient bit RAMP_Q_W-k
  logic                st_v_r    [0:RAMP_Q_W];
  logic [RAMP_N_W-1:0] st_rem_r  [0:RAMP_Q_W];
  logic [RAMP_N_W-1:0] st_rem_nxt[0:RAMP_Q_W];
  logic [RAMP_Q_W-1:0] st_quo_r  [0:RAMP_Q_W];
  logic [RAMP_Q_W-1:0] st_quo_nxt[0:RAMP_Q_W];
  logic [DIST_W-1:0]   st_span_r [0:RAMP_Q_W];
  logic [DIST_W-1:0]   st_dist_r [0:RAMP_Q_W];
  color_cls_t          st_cls_r  [0:RAMP_Q_W];

  logic                out_valid_r;
  logic [DIST_W-1:0]   dist_r;
  logic [COL_W-1:0]    red_r, red_nxt;
  logic [COL_W-1:0]    green_r, green_nxt;
  logic [COL_W-1:0]    blue_r, blue_nxt;
  logic [RAMP_Q_W-1:0] q;

  assign en = !out_valid_r || out_ready;

  always_comb begin
    logic [RAMP_N_W-1:0] trial;
    trial         = '0;
    st_rem_nxt[0] = RAMP_N_W'(in_data.offset) * RAMP_N_W'(RAMP_SPAN);
    st_quo_nxt[0] = '0;
    for (int k = 1; k <= RAMP_Q_W; k++) begin
      trial = RAMP_N_W'(st_span_r[k-1]) << (RAMP_Q_W - k);
      if (st_rem_r[k-1] >= trial) begin
        st_rem_nxt[k] = st_rem_r[k-1] - trial;
        st_quo_nxt[k] = {st_quo_r[k-1][RAMP_Q_W-2:0], 1'b1};
      end else begin
        st_rem_nxt[k] = st_rem_r[k-1];
        st_quo_nxt[k] = {st_quo_r[k-1][RAMP_Q_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    q = st_quo_r[RAMP_Q_W];
    case (st_cls_r[RAMP_Q_W])
      CLS_BLACK: begin
        red_nxt = '0;       green_nxt = '0;       blue_nxt = '0;
      end
      CLS_RED: begin
        red_nxt = COL_FULL; green_nxt = '0;       blue_nxt = '0;
      end
      CLS_MAGENTA: begin
        red_nxt = COL_FULL; green_nxt = '0;       blue_nxt = COL_FULL;
      end
      default: begin
        if (q > SEG_4) begin
          red_nxt = COL_W'(q - SEG_4);  green_nxt = '0;       blue_nxt = COL_FULL;
        end else if (q > SEG_3) begin
          red_nxt = '0;  green_nxt = COL_W'(SEG_4 - q);       blue_nxt = COL_FULL;
        end else if (q > SEG_2) begin
          red_nxt = '0;  green_nxt = COL_FULL;  blue_nxt = COL_W'(q - SEG_2);
        end else if (q > SEG_1) begin
          red_nxt = COL_W'(SEG_2 - q);  green_nxt = COL_FULL; blue_nxt = '0;
        end else begin
          red_nxt = COL_FULL;  green_nxt = COL_W'(q);         blue_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= RAMP_Q_W; k++) begin
        st_v_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      st_v_r[0] <= in_valid;
      for (int k = 1; k <= RAMP_Q_W; k++) begin
        st_v_r[k] <= st_v_r[k-1];
      end
      out_valid_r <= st_v_r[RAMP_Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_rem_r[0]  <= st_rem_nxt[0];
      st_quo_r[0]  <= st_quo_nxt[0];
      st_span_r[0] <= in_data.span;
      st_dist_r[0] <= in_data.dist_mm;
      st_cls_r[0]  <= in_data.cls;
      for (int k = 1; k <= RAMP_Q_W; k++) begin
        st_rem_r[k]  <= st_rem_nxt[k];
        st_quo_r[k]  <= st_quo_nxt[k];
        st_span_r[k] <= st_span_r[k-1];
        st_dist_r[k] <= st_dist_r[k-1];
        st_cls_r[k]  <= st_cls_r[k-1];
      end
      dist_r  <= st_dist_r[RAMP_Q_W];
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_distance_mm = dist_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;

endmodule

>>> tb/tb_tof_pixel_depth_gate_colormap_unit.sv
module tb_tof_pixel_depth_gate_colormap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tpdc_pkg::*;

  // Index with no register behind it; writes to it must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  // Sensor counts that map onto one full unambiguous range.
  localparam int unsigned PHASE_COUNTS = 30000;
  localparam int unsigned RAMP_STEPS   = 1275;
  localparam int          DRAIN_PAD    = 24;
  localparam int          REPORT_LIMIT = 10;

  typedef struct {
    logic [SAMPLE_W-1:0] phase;
    logic [SAMPLE_W-1:0] amplitude;
  } pixel_t;

  typedef struct {
    logic [DIST_W-1:0] depth;
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    color_cls_t        cls;
  } depth_color_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_phase = '0;
  logic [SAMPLE_W-1:0]   in_amplitude = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DIST_W-1:0]     out_distance_mm;
  logic [COL_W-1:0]      out_red;
  logic [COL_W-1:0]      out_green;
  logic [COL_W-1:0]      out_blue;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register image kept by the testbench, updated on every accepted write.
  cfg_t regs_image;

  pixel_t       pixel_backlog[$];
  depth_color_t depth_color_pending[$];

  int  sender_idle_pct = 0;
  int  recv_stall_pct  = 0;
  bit  hold_sender     = 1'b0;
  int  pixels_sent     = 0;
  int  results_seen    = 0;
  int  error_count     = 0;
  int  reg_writes      = 0;
  int  cls_count[4];

  always #6 clk = ~clk;

  tof_pixel_depth_gate_colormap_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_phase        (in_phase),
    .in_amplitude    (in_amplitude),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_distance_mm (out_distance_mm),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Gate the pixel, convert phase to millimeters, then place it on the rainbow ramp.
  function automatic depth_color_t predict_depth_color(pixel_t px);
    depth_color_t     res;
    longint unsigned  ph;
    longint unsigned  amp;
    longint unsigned  mm;
    longint unsigned  q;
    ph  = px.phase & 16'hFFFF;
    amp = px.amplitude & 16'hFFFF;
    mm  = 0;
    q   = 0;
    if (amp >= regs_image.amplitude_min && amp <= regs_image.amplitude_max && ph != 0) begin
      mm = (longint'(regs_image.range_mm) * ph) / PHASE_COUNTS;
      // drop anything outside the distance window, which can include phases past full scale
      if (mm < regs_image.distance_min || mm > regs_image.distance_max) begin
        mm = 0;
      end
    end
    res.depth = mm[DIST_W-1:0];
    if (mm == 0) begin
      res.cls = CLS_BLACK;
      {res.red, res.green, res.blue} = {8'd0, 8'd0, 8'd0};
    end else if (mm < regs_image.color_min) begin
      res.cls = CLS_RED;
      {res.red, res.green, res.blue} = {8'd255, 8'd0, 8'd0};
    end else if (mm > regs_image.color_max) begin
      res.cls = CLS_MAGENTA;
      {res.red, res.green, res.blue} = {8'd255, 8'd0, 8'd255};
    end else begin
      res.cls = CLS_RAMP;
      // an empty span (min equal to max) stays at the start of the ramp
      if (regs_image.color_max > regs_image.color_min) begin
        q = ((mm - regs_image.color_min) * RAMP_STEPS) /
            (regs_image.color_max - regs_image.color_min);
      end
      if (q > 1020) begin
        {res.red, res.green, res.blue} = {COL_W'(q - 1020), 8'd0, 8'd255};
      end else if (q > 765) begin
        {res.red, res.green, res.blue} = {8'd0, COL_W'(1020 - q), 8'd255};
      end else if (q > 510) begin
        {res.red, res.green, res.blue} = {8'd0, 8'd255, COL_W'(q - 510)};
      end else if (q > 255) begin
        {res.red, res.green, res.blue} = {COL_W'(510 - q), 8'd255, 8'd0};
      end else begin
        {res.red, res.green, res.blue} = {8'd255, COL_W'(q), 8'd0};
      end
    end
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_AMP_MIN:   regs_image.amplitude_min = val;
      CFG_AMP_MAX:   regs_image.amplitude_max = val;
      CFG_RANGE_MM:  regs_image.range_mm      = val[DIST_W-1:0];
      CFG_DIST_MIN:  regs_image.distance_min  = val[DIST_W-1:0];
      CFG_DIST_MAX:  regs_image.distance_max  = val[DIST_W-1:0];
      CFG_COLOR_MIN: regs_image.color_min     = val[DIST_W-1:0];
      CFG_COLOR_MAX: regs_image.color_max     = val[DIST_W-1:0];
      default: ;
    endcase
  endfunction

  // Mostly pixels that pass the gates and land in the distance window,
  // the rest random, with zero phase, or sitting just outside the amplitude gate.
  function automatic pixel_t make_pixel(bit well_formed);
    pixel_t          px;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned target;
    longint unsigned ph;
    px.phase     = SAMPLE_W'($urandom);
    px.amplitude = SAMPLE_W'($urandom);
    if (well_formed) begin
      px.amplitude = SAMPLE_W'($urandom_range(regs_image.amplitude_min,
                                              regs_image.amplitude_max));
      lo = (regs_image.distance_min == 0) ? 1 : regs_image.distance_min;
      hi = regs_image.distance_max;
      if ($urandom_range(0, 1) == 1 && regs_image.color_min <= regs_image.color_max) begin
        if (regs_image.color_min > lo) lo = regs_image.color_min;
        if (regs_image.color_max < hi) hi = regs_image.color_max;
      end
      target = $urandom_range(32'(lo), 32'(hi));
      ph = (target * PHASE_COUNTS + regs_image.range_mm - 1) / regs_image.range_mm;
      if (ph > 16'hFFFF) ph = $urandom_range(1, 16'hFFFF);
      if (ph == 0) ph = 1;
      px.phase = ph[SAMPLE_W-1:0];
    end else begin
      case ($urandom_range(0, 3))
        0: ;
        1: px.phase = '0;
        2: px.amplitude = regs_image.amplitude_min - 16'd1;
        default: px.amplitude = regs_image.amplitude_max + 16'd1;
      endcase
    end
    return px;
  endfunction

  function automatic void queue_pixel(logic [SAMPLE_W-1:0] ph, logic [SAMPLE_W-1:0] amp);
    pixel_t px;
    px.phase     = ph;
    px.amplitude = amp;
    pixel_backlog.push_back(px);
  endfunction

  function automatic void set_idle_mode(int mode);
    case (mode)
      0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin sender_idle_pct = 45; recv_stall_pct = 0;  end
      2:       begin sender_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endfunction

  // Issue one register write transaction and mirror it once accepted.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, val);
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(logic [15:0] amp_lo, logic [15:0] amp_hi, logic [15:0] range_v,
                           logic [15:0] mm_lo, logic [15:0] mm_hi,
                           logic [15:0] col_lo, logic [15:0] col_hi);
    write_reg(CFG_AMP_MIN, amp_lo);
    write_reg(CFG_AMP_MAX, amp_hi);
    write_reg(CFG_RANGE_MM, range_v);
    write_reg(CFG_DIST_MIN, mm_lo);
    write_reg(CFG_DIST_MAX, mm_hi);
    write_reg(CFG_COLOR_MIN, col_lo);
    write_reg(CFG_COLOR_MAX, col_hi);
  endtask

  // Queue a burst under one idling mode and wait until the driver has taken it.
  task automatic random_burst(int count, int mode);
    set_idle_mode(mode);
    repeat (count) pixel_backlog.push_back(make_pixel($urandom_range(0, 99) < 75));
    do @(posedge clk); while (pixel_backlog.size() != 0);
  endtask

  // Wait until every pixel has been sent and every result returned, then let the
  // pipeline settle for longer than its depth before touching registers.
  task automatic drain_all();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || in_valid || depth_color_pending.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Pixel driver: hold the payload while stalled, otherwise advance from the backlog.
  always @(posedge clk) begin : drive_pixels
    pixel_t taken;
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.phase     = in_phase;
        taken.amplitude = in_amplitude;
        depth_color_pending.push_back(predict_depth_color(taken));
        pixels_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the current transaction
      end else if (!hold_sender && pixel_backlog.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = pixel_backlog.pop_front();
        in_phase     <= nxt.phase;
        in_amplitude <= nxt.amplitude;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each accepted transaction against the oldest prediction.
  always @(posedge clk) begin : check_results
    depth_color_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (depth_color_pending.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("[%0t] unexpected result: depth %0d rgb (%0d,%0d,%0d)", $realtime,
                     out_distance_mm, out_red, out_green, out_blue);
        end else begin
          want = depth_color_pending.pop_front();
          results_seen++;
          cls_count[want.cls]++;
          if (out_distance_mm !== want.depth || out_red !== want.red ||
              out_green !== want.green || out_blue !== want.blue) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("[%0t] mismatch: expected depth %0d rgb (%0d,%0d,%0d), got %0d (%0d,%0d,%0d)",
                       $realtime, want.depth, want.red, want.green, want.blue,
                       out_distance_mm, out_red, out_green, out_blue);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    regs_image.amplitude_min = 16'd50;
    regs_image.amplitude_max = 16'd60000;
    regs_image.range_mm      = 15'd12500;
    regs_image.distance_min  = 15'd300;
    regs_image.distance_max  = 15'd12500;
    regs_image.color_min     = 15'd0;
    regs_image.color_max     = 15'd15000;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: amplitude gate edges, zero phase, distance window edges,
    // phase past full scale and each boundary between ramp segments.
    set_idle_mode(0);
    queue_pixel(16'd0,     16'd1000);
    queue_pixel(16'd7200,  16'd49);
    queue_pixel(16'd7200,  16'd50);
    queue_pixel(16'd7200,  16'd60000);
    queue_pixel(16'd7200,  16'd60001);
    queue_pixel(16'd7200,  16'd0);
    queue_pixel(16'd7200,  16'hFFFF);
    queue_pixel(16'hFFFF,  16'd1000);
    queue_pixel(16'd30000, 16'd1000);
    queue_pixel(16'd30003, 16'd1000);
    queue_pixel(16'd720,   16'd1000);
    queue_pixel(16'd719,   16'd1000);
    queue_pixel(16'd7229,  16'd1000);
    queue_pixel(16'd14400, 16'd1000);
    queue_pixel(16'd14429, 16'd1000);
    queue_pixel(16'd21600, 16'd1000);
    queue_pixel(16'd21629, 16'd1000);
    queue_pixel(16'd28800, 16'd1000);
    queue_pixel(16'd28829, 16'd1000);
    random_burst(100, 0);
    drain_all();

    // Widest settings: every register at an extreme.
    load_regs(16'd0, 16'hFFFF, 16'd32767, 16'd0, 16'd32767, 16'd0, 16'd32767);
    queue_pixel(16'hFFFF,  16'hFFFF);
    queue_pixel(16'd1,     16'd0);
    queue_pixel(16'd30000, 16'd0);
    random_burst(100, 1);
    drain_all();

    // Empty color span; upper bits of 15-bit registers must be dropped, and a
    // write to the unused index must change nothing.
    write_reg(CFG_RANGE_MM, 16'h8000 | 16'd30000);
    write_reg(CFG_AMP_MIN, 16'd100);
    write_reg(CFG_AMP_MAX, 16'd50000);
    write_reg(CFG_DIST_MIN, 16'd1000);
    write_reg(CFG_DIST_MAX, 16'h8000 | 16'd20000);
    write_reg(CFG_COLOR_MIN, 16'd5000);
    write_reg(CFG_COLOR_MAX, 16'd5000);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    queue_pixel(16'd5000, 16'd1000);
    queue_pixel(16'd4999, 16'd1000);
    queue_pixel(16'd5001, 16'd1000);
    queue_pixel(16'd999,  16'd1000);
    queue_pixel(16'd1000, 16'd1000);
    random_burst(100, 2);
    drain_all();

    // Reversed color span, single-value amplitude gate at the top.
    load_regs(16'hFFFF, 16'hFFFF, 16'd30000, 16'd0, 16'd32767, 16'd8000, 16'd2000);
    random_burst(50, 3);
    // Pause the sender until the pipeline is empty, then resume mid-phase.
    hold_sender = 1'b1;
    do @(posedge clk); while (in_valid || depth_color_pending.size() != 0);
    repeat ($urandom_range(1, 20)) @(posedge clk);
    hold_sender = 1'b0;
    random_burst(50, 3);
    drain_all();

    // Smallest range: distances collapse to 0, 1 or 2 on a two-step ramp.
    load_regs(16'd0, 16'd0, 16'd1, 16'd0, 16'd2, 16'd0, 16'd2);
    for (int m = 0; m < 4; m++) random_burst(25, m);
    drain_all();

    // Random settings, with idling modes picked at random.
    for (int p = 0; p < 2; p++) begin : random_settings
      int lo_mm;
      int lo_col;
      lo_mm  = $urandom_range(0, 2000);
      lo_col = $urandom_range(0, 10000);
      load_regs(16'($urandom_range(0, 3000)), 16'($urandom_range(20000, 65535)),
                16'($urandom_range(1, 32767)), 16'(lo_mm),
                16'($urandom_range(lo_mm, 32767)),
                16'(lo_col), 16'($urandom_range(lo_col + 1, 32767)));
      for (int m = 0; m < 4; m++) random_burst(20, $urandom_range(0, 3));
      drain_all();
    end

    $display("Covered %0d pixels across %0d register writes, %0d results compared",
             pixels_sent, reg_writes, results_seen);
    $display("Colors seen: black %0d, red %0d, magenta %0d, ramp %0d; %0d errors",
             cls_count[CLS_BLACK], cls_count[CLS_RED], cls_count[CLS_MAGENTA],
             cls_count[CLS_RAMP], error_count);
    if (error_count == 0 && depth_color_pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Watchdog expired with %0d results outstanding", depth_color_pending.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/tpdc_pkg.sv
sv/tpdc_queue.sv
sv/tpdc_front.sv
sv/tpdc_depth.sv
sv/tpdc_ramp.sv
sv/tof_pixel_depth_gate_colormap_unit.sv
tb/tb_tof_pixel_depth_gate_colormap_unit.sv
